### src/bwts_pkg.sv
// Shared types, constants and helper functions of the bilinear wrap texture sampler.
`timescale 1ns / 1ps
`default_nettype none

package bwts_pkg;

  // Field and datapath widths.
  localparam int unsigned DIM_W      = 9;
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned NUM_CHAN   = 3;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned TEXEL_W    = NUM_CHAN * CHAN_W;
  localparam int unsigned OUT_W      = 24;
  localparam int unsigned COORD_W    = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned NUM_TAPS   = 4;

  // Remainder unit: dividend is the integer part of v*width, two bits per step.
  localparam int unsigned DIVIDEND_W    = 26;
  localparam int unsigned BITS_PER_STEP = 2;
  localparam int unsigned DIV_STEPS     = DIVIDEND_W / BITS_PER_STEP;
  localparam int unsigned DIV_CNT_W     = $clog2(DIV_STEPS + 1);

  // Operation codes.
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  // 255.0 in 8.16 fixed point, and one half texel in 16 fraction bits.
  localparam logic [OUT_W-1:0]  FULL_SCALE = 24'd16711680;
  localparam logic [FRAC_W-1:0] HALF_TEXEL = 16'h8000;

  // Request and response of the iterative remainder unit.
  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIM_W-1:0]      divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIM_W-1:0] rem;
  } div_rsp_t;

  // Low and high texel index along one axis and the weight of the high texel.
  typedef struct packed {
    logic [DIM_W-1:0]  lo;
    logic [DIM_W-1:0]  hi;
    logic [FRAC_W-1:0] frac;
  } axis_pos_t;

  // Shifts a position back by half a texel and wraps both neighbors into [0, size).
  function automatic axis_pos_t locate(input logic [DIM_W-1:0]  whole,
                                       input logic [FRAC_W-1:0] frac,
                                       input logic [DIM_W-1:0]  size);
    logic [DIM_W:0] low;
    logic [DIM_W:0] nxt;
    axis_pos_t      pos;
    low = {1'b0, whole} + {1'b0, size} - {{DIM_W{1'b0}}, ~frac[FRAC_W-1]};
    if (low >= {1'b0, size}) begin
      low = low - {1'b0, size};
    end
    nxt = low + {{DIM_W{1'b0}}, 1'b1};
    pos.lo   = low[DIM_W-1:0];
    pos.hi   = (nxt == {1'b0, size}) ? '0 : nxt[DIM_W-1:0];
    pos.frac = frac ^ HALF_TEXEL;
    return pos;
  endfunction

endpackage

`default_nettype wire

### src/bwts_texmem.sv
// Single-port texel memory with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module bwts_texmem import bwts_pkg::*; #(
  parameter int unsigned ADDR_W = 16
) (
  input  wire logic               clk_i,
  input  wire logic               we_i,
  input  wire logic [ADDR_W-1:0]  addr_i,
  input  wire logic [TEXEL_W-1:0] wdata_i,
  output logic      [TEXEL_W-1:0] rdata_o
);

  localparam int unsigned DEPTH = 1 << ADDR_W;

  logic [TEXEL_W-1:0] mem [DEPTH];
  logic [TEXEL_W-1:0] rdata_q;

  // One access per cycle; the read data is registered and appears in the cycle after the address.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### src/bwts_remdiv.sv
// Iterative remainder unit that reduces an unsigned dividend modulo the image height.
`timescale 1ns / 1ps
`default_nettype none

module bwts_remdiv import bwts_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  logic                  busy_q, busy_d;
  logic [DIV_CNT_W-1:0]  cnt_q, cnt_d;
  logic [DIVIDEND_W-1:0] dvd_q, dvd_d;
  logic [DIM_W-1:0]      rem_q, rem_d;
  logic [DIM_W-1:0]      dsr_q, dsr_d;
  logic [DIVIDEND_W-1:0] dvd_step;
  logic [DIM_W-1:0]      rem_step;
  logic [DIM_W:0]        trial;

  // Restoring remainder, two dividend bits per cycle.
  always_comb begin
    rem_step = rem_q;
    dvd_step = dvd_q;
    trial    = '0;
    for (int j = 0; j < BITS_PER_STEP; j++) begin
      trial    = {rem_step, dvd_step[DIVIDEND_W-1]};
      dvd_step = {dvd_step[DIVIDEND_W-2:0], 1'b0};
      if (trial >= {1'b0, dsr_q}) begin
        rem_step = DIM_W'(trial - {1'b0, dsr_q});
      end else begin
        rem_step = trial[DIM_W-1:0];
      end
    end
  end

  // Load on start, step while the count runs, then report done for one cycle.
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DIV_STEPS);
      dvd_d  = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        cnt_d = cnt_q - DIV_CNT_W'(1);
        dvd_d = dvd_step;
        rem_d = rem_step;
      end else begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done = busy_q && (cnt_q == '0);
  assign rsp_o.rem  = rem_q;

endmodule

`default_nettype wire

### src/bwts_blend.sv
// Two-stage bilinear blend: horizontal lerps into registers, then the rounded vertical lerp.
`timescale 1ns / 1ps
`default_nettype none

module bwts_blend import bwts_pkg::*; (
  input  wire logic                               clk_i,
  input  wire logic                               h_en_i,
  input  wire logic [NUM_TAPS-1:0][TEXEL_W-1:0]   texel_i,
  input  wire logic [FRAC_W-1:0]                  fx_i,
  input  wire logic [FRAC_W-1:0]                  fy_i,
  output logic      [NUM_CHAN-1:0][OUT_W-1:0]     mix_o
);

  logic [NUM_CHAN-1:0][OUT_W-1:0] top_q, top_d;
  logic [NUM_CHAN-1:0][OUT_W-1:0] bot_q, bot_d;
  logic [FRAC_W-1:0]              fy_q;

  // a*(1-f) + b*f written as a + (b-a)*f; exact in 8.16.
  function automatic logic [OUT_W-1:0] lerp_h(input logic [CHAN_W-1:0] a,
                                              input logic [CHAN_W-1:0] b,
                                              input logic [FRAC_W-1:0] f);
    logic signed [CHAN_W:0]          diff;
    logic signed [CHAN_W+FRAC_W+1:0] prod;
    logic signed [CHAN_W+FRAC_W+1:0] sum;
    diff = $signed({1'b0, b}) - $signed({1'b0, a});
    prod = diff * $signed({1'b0, f});
    sum  = $signed({2'b00, a, {FRAC_W{1'b0}}}) + prod;
    return sum[OUT_W-1:0];
  endfunction

  // Same blend on 8.16 values, rounded half up back to 8.16.
  function automatic logic [OUT_W-1:0] lerp_v(input logic [OUT_W-1:0]  a,
                                              input logic [OUT_W-1:0]  b,
                                              input logic [FRAC_W-1:0] f);
    logic signed [OUT_W:0]          diff;
    logic signed [OUT_W+FRAC_W+1:0] prod;
    logic signed [OUT_W+FRAC_W+1:0] sum;
    diff = $signed({1'b0, b}) - $signed({1'b0, a});
    prod = diff * $signed({1'b0, f});
    sum  = $signed({2'b00, a, {FRAC_W{1'b0}}}) + prod
         + $signed({{(OUT_W+2){1'b0}}, HALF_TEXEL});
    return sum[OUT_W+FRAC_W-1:FRAC_W];
  endfunction

  // Horizontal pass: taps are top-left, top-right, bottom-left, bottom-right.
  always_comb begin
    for (int k = 0; k < NUM_CHAN; k++) begin
      top_d[k] = lerp_h(texel_i[0][TEXEL_W-1-CHAN_W*k -: CHAN_W],
                        texel_i[1][TEXEL_W-1-CHAN_W*k -: CHAN_W], fx_i);
      bot_d[k] = lerp_h(texel_i[2][TEXEL_W-1-CHAN_W*k -: CHAN_W],
                        texel_i[3][TEXEL_W-1-CHAN_W*k -: CHAN_W], fx_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (h_en_i) begin
      top_q <= top_d;
      bot_q <= bot_d;
      fy_q  <= fy_i;
    end
  end

  // Vertical pass from the registered rows.
  always_comb begin
    for (int k = 0; k < NUM_CHAN; k++) begin
      mix_o[k] = lerp_v(top_q[k], bot_q[k], fy_q);
    end
  end

endmodule

`default_nettype wire

### src/bilinear_wrap_texture_sampler_top.sv
// Top level of the bilinear wrap texture sampler: control sequencer and address generation.
//
// Usage. The input channel carries two kinds of transaction. A write transaction
// (opcode write) stores one RGB texel at (texel_col, texel_row) and returns nothing;
// it leaves the input ready, so writes can stream back to back. A sample transaction
// (opcode sample) takes coordinates u and v in signed Q15.16 and returns one result
// on the output channel: red, green and blue in unsigned 8.16, blended from the four
// wrapped texels around the sample point. With an image width of zero the result is
// pure green. The configuration channel sets image width and height and is always
// ready; write it only while the block is idle.
// The input is not ready again until a sample has finished, so a new transaction is
// taken only after the result of a sample has been loaded into the output register.
// The sample time is set by the 13-step remainder unit (two bits per cycle over a 26-bit
// dividend) and by the four reads of the single-port texel memory. Without an image
// the sequencer skips the remainder unit and the reads and goes to the final stage.
// Reset clears the sequencer, the configuration (width 0, height 1) and the output
// valid; the texel memory is not cleared, so texels must be written before use.
// When the receiver stalls, the finished result waits in the output register and a
// new transaction is still taken; a second sample waits before its final stage.
`timescale 1ns / 1ps
`default_nettype none

module bilinear_wrap_texture_sampler_top import bwts_pkg::*; #(
  parameter int unsigned MAX_SIDE = 256
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // Input transactions.
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 opcode_i,
  input  wire logic [CHAN_W-1:0]    texel_col_i,
  input  wire logic [CHAN_W-1:0]    texel_row_i,
  input  wire logic [CHAN_W-1:0]    red_in_i,
  input  wire logic [CHAN_W-1:0]    green_in_i,
  input  wire logic [CHAN_W-1:0]    blue_in_i,
  input  wire logic [COORD_W-1:0]   coord_u_i,
  input  wire logic [COORD_W-1:0]   coord_v_i,
  // Result transactions.
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic      [OUT_W-1:0]     red_out_o,
  output logic      [OUT_W-1:0]     green_out_o,
  output logic      [OUT_W-1:0]     blue_out_o,
  // Configuration writes.
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [DIM_W-1:0]     cfg_data_i
);

  localparam int unsigned IDX_W    = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 1;
  localparam int unsigned EXT_W    = (IDX_W > DIM_W) ? IDX_W : DIM_W;
  localparam int unsigned ADDR_W   = 2 * IDX_W;
  localparam int unsigned DIM_MAX  = (1 << DIM_W) - 1;
  localparam int unsigned SIDE_CAP = (MAX_SIDE > DIM_MAX) ? DIM_MAX : MAX_SIDE;
  localparam int unsigned WR_MAX   = 1 << CHAN_W;
  localparam int unsigned WR_LIM   = (MAX_SIDE > WR_MAX) ? WR_MAX : MAX_SIDE;
  localparam logic [DIM_W-1:0]  SIDE_CAP_V = DIM_W'(SIDE_CAP);
  localparam logic [CHAN_W:0]   WR_LIM_V   = (CHAN_W + 1)'(WR_LIM);
  localparam int unsigned XQ_W = FRAC_W + DIM_W;
  localparam int unsigned PV_W = COORD_W + DIM_W + 1;

  // Sequencer states.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL  = 4'd1;
  localparam logic [3:0] S_DIV  = 4'd2;
  localparam logic [3:0] S_LOC  = 4'd3;
  localparam logic [3:0] S_RD0  = 4'd4;
  localparam logic [3:0] S_RD1  = 4'd5;
  localparam logic [3:0] S_RD2  = 4'd6;
  localparam logic [3:0] S_RD3  = 4'd7;
  localparam logic [3:0] S_RDL  = 4'd8;
  localparam logic [3:0] S_HBL  = 4'd9;
  localparam logic [3:0] S_VBL  = 4'd10;

  logic [3:0]                       state_q, state_d;
  logic [DIM_W-1:0]                 width_q, width_d;
  logic [DIM_W-1:0]                 height_q, height_d;
  logic                             out_valid_q, out_valid_d;
  logic [OUT_W-1:0]                 red_q, red_d;
  logic [OUT_W-1:0]                 green_q, green_d;
  logic [OUT_W-1:0]                 blue_q, blue_d;

  logic [FRAC_W-1:0]                u_frac_q;
  logic [COORD_W-1:0]               v_q;
  logic [DIM_W-1:0]                 w_q, h_q;
  logic                             noimg_q;
  logic [XQ_W-1:0]                  xq_q;
  logic [FRAC_W-1:0]                plo_q;
  logic                             neg_q;
  axis_pos_t                        xpos_q, ypos_q, xpos_d, ypos_d;
  logic [NUM_TAPS-1:0][TEXEL_W-1:0] tex_q;

  logic                             in_acc;
  logic                             do_write;
  logic [DIM_W-1:0]                 w_clamp, h_clamp;
  logic signed [PV_W-1:0]           prod_v;
  logic [XQ_W-1:0]                  prod_x;
  logic [DIVIDEND_W-2:0]            p_hi, p_mag;
  logic [DIM_W-1:0]                 y_whole;
  logic                             out_free;

  logic                             mem_we;
  logic [ADDR_W-1:0]                mem_addr, wr_addr, rd_addr;
  logic [TEXEL_W-1:0]               mem_rdata;
  div_req_t                         div_req;
  div_rsp_t                         div_rsp;
  logic [NUM_CHAN-1:0][OUT_W-1:0]   mix;

  // Row-major texel address; indexes are below MAX_SIDE when they reach here.
  function automatic logic [ADDR_W-1:0] tex_addr(input logic [DIM_W-1:0] col,
                                                 input logic [DIM_W-1:0] row);
    logic [EXT_W-1:0] c;
    logic [EXT_W-1:0] r;
    c = EXT_W'(col);
    r = EXT_W'(row);
    return {r[IDX_W-1:0], c[IDX_W-1:0]};
  endfunction

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  // Effective image size: width and height clamped to the memory side, height at least one.
  assign w_clamp = (width_q > SIDE_CAP_V) ? SIDE_CAP_V : width_q;
  assign h_clamp = (height_q == '0) ? DIM_W'(1) :
                   ((height_q > SIDE_CAP_V) ? SIDE_CAP_V : height_q);

  // Configuration register writes.
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_IMAGE_WIDTH:  width_d  = cfg_data_i;
        CFG_IMAGE_HEIGHT: height_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  // Texel writes go straight to the memory while the sequencer is idle.
  assign do_write = in_acc && (opcode_i == OP_WRITE) &&
                    ({1'b0, texel_col_i} < WR_LIM_V) && ({1'b0, texel_row_i} < WR_LIM_V);
  assign mem_we   = do_write;
  assign wr_addr  = tex_addr(DIM_W'(texel_col_i), DIM_W'(texel_row_i));

  // Read address for the four taps.
  always_comb begin
    case (state_q)
      S_RD1:   rd_addr = tex_addr(xpos_q.hi, ypos_q.lo);
      S_RD2:   rd_addr = tex_addr(xpos_q.lo, ypos_q.hi);
      S_RD3:   rd_addr = tex_addr(xpos_q.hi, ypos_q.hi);
      default: rd_addr = tex_addr(xpos_q.lo, ypos_q.lo);
    endcase
  end
  assign mem_addr = (state_q == S_IDLE) ? wr_addr : rd_addr;

  // Texel positions: x = frac(u)*w, and v*w split into an integer part for the
  // remainder unit and 16 fraction bits that pass through unchanged.
  assign prod_x  = u_frac_q * w_q;
  assign prod_v  = $signed(v_q) * $signed({1'b0, w_q});
  assign p_hi    = prod_v[PV_W-2:FRAC_W];
  assign p_mag   = prod_v[PV_W-1] ? (DIVIDEND_W-1)'(-p_hi) : p_hi;

  assign div_req.start    = (state_q == S_MUL) && !noimg_q;
  assign div_req.dividend = {1'b0, p_mag};
  assign div_req.divisor  = h_q;

  // Floor modulo: a negative product folds its remainder back from the height.
  assign y_whole = (neg_q && (div_rsp.rem != '0)) ? (h_q - div_rsp.rem) : div_rsp.rem;
  assign xpos_d  = locate(xq_q[XQ_W-1:FRAC_W], xq_q[FRAC_W-1:0], w_q);
  assign ypos_d  = locate(y_whole, plo_q, h_q);

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && (opcode_i == OP_SAMPLE)) begin
          state_d = S_MUL;
        end
      end
      S_MUL:  state_d = noimg_q ? S_VBL : S_DIV;
      S_DIV: begin
        if (div_rsp.done) begin
          state_d = S_LOC;
        end
      end
      S_LOC:  state_d = S_RD0;
      S_RD0:  state_d = S_RD1;
      S_RD1:  state_d = S_RD2;
      S_RD2:  state_d = S_RD3;
      S_RD3:  state_d = S_RDL;
      S_RDL:  state_d = S_HBL;
      S_HBL:  state_d = S_VBL;
      S_VBL: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output register: loaded in the final stage, held while the receiver stalls.
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    red_d       = red_q;
    green_d     = green_q;
    blue_d      = blue_q;
    if ((state_q == S_VBL) && out_free) begin
      out_valid_d = 1'b1;
      if (noimg_q) begin
        red_d   = '0;
        green_d = FULL_SCALE;
        blue_d  = '0;
      end else begin
        red_d   = mix[0];
        green_d = mix[1];
        blue_d  = mix[2];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      width_q     <= '0;
      height_q    <= DIM_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      width_q     <= width_d;
      height_q    <= height_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Sample payload and intermediate results.
  always_ff @(posedge clk_i) begin
    red_q   <= red_d;
    green_q <= green_d;
    blue_q  <= blue_d;
    if (in_acc && (opcode_i == OP_SAMPLE)) begin
      u_frac_q <= coord_u_i[FRAC_W-1:0];
      v_q      <= coord_v_i;
      w_q      <= w_clamp;
      h_q      <= h_clamp;
      noimg_q  <= (width_q == '0);
    end
    if (state_q == S_MUL) begin
      xq_q  <= prod_x;
      plo_q <= prod_v[FRAC_W-1:0];
      neg_q <= prod_v[PV_W-1];
    end
    if (state_q == S_LOC) begin
      xpos_q <= xpos_d;
      ypos_q <= ypos_d;
    end
    // Read data arrives in the cycle after each address; shift it in tap order.
    if ((state_q == S_RD1) || (state_q == S_RD2) || (state_q == S_RD3) ||
        (state_q == S_RDL)) begin
      tex_q <= {mem_rdata, tex_q[NUM_TAPS-1:1]};
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_out_o   = red_q;
  assign green_out_o = green_q;
  assign blue_out_o  = blue_q;

  bwts_texmem #(
    .ADDR_W (ADDR_W)
  ) u_texmem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i ({red_in_i, green_in_i, blue_in_i}),
    .rdata_o (mem_rdata)
  );

  bwts_remdiv u_remdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  bwts_blend u_blend (
    .clk_i   (clk_i),
    .h_en_i  (state_q == S_HBL),
    .texel_i (tex_q),
    .fx_i    (xpos_q.frac),
    .fy_i    (ypos_q.frac),
    .mix_o   (mix)
  );

endmodule

`default_nettype wire

### src/bwts_checker.sv
// Port-level assertions for the sampler top level, attached by a bind statement.
`timescale 1ns / 1ps
`default_nettype none

module bwts_checker import bwts_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_ready_o,
  input wire logic             opcode_i,
  input wire logic             out_valid_o,
  input wire logic             out_ready_i,
  input wire logic [OUT_W-1:0] red_out_o,
  input wire logic [OUT_W-1:0] green_out_o,
  input wire logic [OUT_W-1:0] blue_out_o
);

  // A stalled result stays valid and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(red_out_o) &&
                                    $stable(green_out_o) && $stable(blue_out_o))
    else $error("stalled result changed or dropped");

  // A sample transaction keeps the input side busy through the multiply state and the state after it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (opcode_i == OP_SAMPLE) |=> !in_ready_o ##1 !in_ready_o)
    else $error("input taken too early after a sample");

  // A texel write leaves the input side ready for the next transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (opcode_i == OP_WRITE) |=> in_ready_o)
    else $error("texel write stalled the input");

  // Blended channels never exceed full scale.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (red_out_o <= FULL_SCALE) && (green_out_o <= FULL_SCALE) &&
                    (blue_out_o <= FULL_SCALE))
    else $error("channel above full scale");

endmodule

bind bilinear_wrap_texture_sampler_top bwts_checker u_bwts_checker (.*);

`default_nettype wire

### bench/bilinear_wrap_texture_sampler_top_tb.sv
// Self-checking testbench for the bilinear wrap texture sampler top level.
`timescale 1ns / 1ps

module bilinear_wrap_texture_sampler_top_tb;
  import bwts_pkg::*;

  localparam int unsigned TEX_SIDE        = 256;
  localparam int          CLK_HALF        = 2;
  localparam int          RESET_CYCLES    = 11;
  localparam int          SETTLE_CYCLES   = 32;
  localparam int          HOLD_CYCLES     = 400;
  localparam int          WATCHDOG_LIMIT  = 4000;
  localparam int          MAX_PRINTED     = 100;
  localparam int          NUM_DIRECTED    = 33;
  localparam int          NUM_PHASES      = 10;
  localparam int          PHASE_ITEMS     = 175;
  localparam int          HOLD_PHASE      = 2;

  // Register indexes that the block decodes to nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  typedef enum logic [1:0] {ROW_CONFIG, ROW_WRITE, ROW_SAMPLE} row_kind_e;
  typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic [OUT_W-1:0] red;
    logic [OUT_W-1:0] green;
    logic [OUT_W-1:0] blue;
  } rgb_result_t;

  // One line of the directed table: a register write, a texel write or a sample.
  typedef struct packed {
    row_kind_e          kind;
    logic [DIM_W-1:0]   a;
    logic [DIM_W-1:0]   b;
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
    logic [COORD_W-1:0] u;
    logic [COORD_W-1:0] v;
    logic               has_typed;
    rgb_result_t        typed_rgb;
  } dir_row_t;

  // Where the expected result of a sample comes from.
  typedef struct {
    bit          fixed;
    rgb_result_t val;
  } sample_origin_t;

  // Texel coordinates and weights touched by one sample.
  typedef struct packed {
    logic [CHAN_W-1:0] x0;
    logic [CHAN_W-1:0] x1;
    logic [CHAN_W-1:0] y0;
    logic [CHAN_W-1:0] y1;
    logic [FRAC_W-1:0] fx;
    logic [FRAC_W-1:0] fy;
  } taps_t;

  // Clock, reset and block ports.
  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid    = 1'b0;
  logic               in_ready;
  logic               opcode      = OP_WRITE;
  logic [CHAN_W-1:0]  texel_col   = '0;
  logic [CHAN_W-1:0]  texel_row   = '0;
  logic [CHAN_W-1:0]  red_in      = '0;
  logic [CHAN_W-1:0]  green_in    = '0;
  logic [CHAN_W-1:0]  blue_in     = '0;
  logic [COORD_W-1:0] coord_u     = '0;
  logic [COORD_W-1:0] coord_v     = '0;
  logic               out_valid;
  logic               out_ready   = 1'b0;
  logic [OUT_W-1:0]   red_out;
  logic [OUT_W-1:0]   green_out;
  logic [OUT_W-1:0]   blue_out;
  logic               cfg_valid   = 1'b0;
  logic               cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]   cfg_data    = '0;

  // Model state: configuration, texture contents and pending results.
  logic [DIM_W-1:0]   model_width  = '0;
  logic [DIM_W-1:0]   model_height = 9'd1;
  logic [TEXEL_W-1:0] texel_shadow [TEX_SIDE*TEX_SIDE];
  bit                 tex_written  [TEX_SIDE*TEX_SIDE];
  rgb_result_t        expected_rgb_q [$];
  sample_origin_t     sample_origin_q [$];

  // Run bookkeeping.
  int mismatches              = 0;
  int items_sent              = 0;
  int cycles_without_progress = 0;
  int sender_idle_pct         = 0;
  int recv_stall_pct          = 0;
  int hold_left               = 0;
  bit hold_request            = 1'b0;

  dir_row_t directed_rows [NUM_DIRECTED];

  bilinear_wrap_texture_sampler_top #(
    .MAX_SIDE(TEX_SIDE)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .opcode_i   (opcode),
    .texel_col_i(texel_col),
    .texel_row_i(texel_row),
    .red_in_i   (red_in),
    .green_in_i (green_in),
    .blue_in_i  (blue_in),
    .coord_u_i  (coord_u),
    .coord_v_i  (coord_v),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .red_out_o  (red_out),
    .green_out_o(green_out),
    .blue_out_o (blue_out),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  // Free-running clock.
  always begin
    #(CLK_HALF) clk_i = 1'b1;
    #(CLK_HALF) clk_i = 1'b0;
  end

  // Splits a position with 16 fraction bits into the two neighbor texels and the
  // weight of the upper one, shifted back by half a texel and wrapped into [0, size).
  function automatic void split_axis(input longint unsigned pos, input int unsigned size,
                                     output int unsigned lo, output int unsigned hi,
                                     output int unsigned wt);
    longint unsigned t;
    t  = pos + (64'(size) << 16) - 64'd32768;
    lo = 32'(t >> 16);
    if (lo >= size) begin
      lo = lo - size;
    end
    hi = lo + 1;
    if (hi >= size) begin
      hi = 0;
    end
    wt = 32'(t & 64'hFFFF);
  endfunction

  // Finds the four texels and the weights that a sample at (u, v) uses.
  function automatic taps_t find_taps(input logic [COORD_W-1:0] u, input logic [COORD_W-1:0] v,
                                      input logic [DIM_W-1:0] w_reg,
                                      input logic [DIM_W-1:0] h_reg);
    int unsigned w, h, lo, hi, wt;
    longint      prod, span, rem;
    taps_t       tp;
    w = (w_reg > TEX_SIDE) ? TEX_SIDE : w_reg;
    h = (h_reg == 0) ? 1 : ((h_reg > TEX_SIDE) ? TEX_SIDE : h_reg);
    split_axis(64'(u[FRAC_W-1:0]) * 64'(w), w, lo, hi, wt);
    tp.x0 = lo[CHAN_W-1:0];
    tp.x1 = hi[CHAN_W-1:0];
    tp.fx = wt[FRAC_W-1:0];
    // The vertical position is v times the width, wrapped into the height.
    prod = longint'($signed(v)) * longint'(w);
    span = longint'(h) << 16;
    rem  = prod % span;
    if (rem < 0) begin
      rem = rem + span;
    end
    split_axis(rem, h, lo, hi, wt);
    tp.y0 = lo[CHAN_W-1:0];
    tp.y1 = hi[CHAN_W-1:0];
    tp.fy = wt[FRAC_W-1:0];
    return tp;
  endfunction

  // Computes the blended color of a sample from the shadow texture.
  function automatic rgb_result_t predict_rgb(input logic [COORD_W-1:0] u,
                                              input logic [COORD_W-1:0] v,
                                              input logic [DIM_W-1:0] w_reg,
                                              input logic [DIM_W-1:0] h_reg);
    taps_t           tp;
    logic [TEXEL_W-1:0] tl, tr, bl, br;
    longint unsigned fx, fy, top, bot, mid;
    logic [OUT_W-1:0] mix [NUM_CHAN];
    rgb_result_t     res;
    if (w_reg == 0) begin
      res.red   = '0;
      res.green = FULL_SCALE;
      res.blue  = '0;
      return res;
    end
    tp = find_taps(u, v, w_reg, h_reg);
    tl = texel_shadow[{tp.y0, tp.x0}];
    tr = texel_shadow[{tp.y0, tp.x1}];
    bl = texel_shadow[{tp.y1, tp.x0}];
    br = texel_shadow[{tp.y1, tp.x1}];
    fx = 64'(tp.fx);
    fy = 64'(tp.fy);
    // Channel 0 is blue in the low byte, channel 2 is red in the high byte.
    for (int k = 0; k < NUM_CHAN; k++) begin
      top = 64'(tl[CHAN_W*k +: CHAN_W]) * (64'd65536 - fx) + 64'(tr[CHAN_W*k +: CHAN_W]) * fx;
      bot = 64'(bl[CHAN_W*k +: CHAN_W]) * (64'd65536 - fx) + 64'(br[CHAN_W*k +: CHAN_W]) * fx;
      mid = (top * (64'd65536 - fy) + bot * fy + 64'd32768) >> 16;
      mix[k] = mid[OUT_W-1:0];
    end
    res.red   = mix[2];
    res.green = mix[1];
    res.blue  = mix[0];
    return res;
  endfunction

  // Table entry builders.
  function automatic dir_row_t tbl_cfg(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [DIM_W-1:0] data);
    dir_row_t e;
    e      = '0;
    e.kind = ROW_CONFIG;
    e.a    = DIM_W'(idx);
    e.b    = data;
    return e;
  endfunction

  function automatic dir_row_t tbl_write(input logic [CHAN_W-1:0] col,
                                         input logic [CHAN_W-1:0] row,
                                         input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                                         input logic [CHAN_W-1:0] b);
    dir_row_t e;
    e       = '0;
    e.kind  = ROW_WRITE;
    e.a     = DIM_W'(col);
    e.b     = DIM_W'(row);
    e.red   = r;
    e.green = g;
    e.blue  = b;
    return e;
  endfunction

  function automatic dir_row_t tbl_sample(input logic [COORD_W-1:0] u,
                                          input logic [COORD_W-1:0] v);
    dir_row_t e;
    e      = '0;
    e.kind = ROW_SAMPLE;
    e.u    = u;
    e.v    = v;
    return e;
  endfunction

  function automatic dir_row_t tbl_sample_known(input logic [COORD_W-1:0] u,
                                                input logic [COORD_W-1:0] v,
                                                input logic [OUT_W-1:0] r,
                                                input logic [OUT_W-1:0] g,
                                                input logic [OUT_W-1:0] b);
    dir_row_t e;
    e           = tbl_sample(u, v);
    e.has_typed = 1'b1;
    e.typed_rgb = '{red: r, green: g, blue: b};
    return e;
  endfunction

  // Random coordinate: full range, texel-edge fractions, or small magnitudes of both signs.
  function automatic logic [COORD_W-1:0] rand_coord();
    logic [COORD_W-1:0] c;
    c = $urandom;
    case ($urandom_range(7))
      0, 1: begin
      end
      2: begin
        case ($urandom_range(3))
          0: c[FRAC_W-1:0] = 16'h0000;
          1: c[FRAC_W-1:0] = 16'h7FFF;
          2: c[FRAC_W-1:0] = 16'h8000;
          default: c[FRAC_W-1:0] = 16'hFFFF;
        endcase
      end
      default: begin
        c = $signed(c) >>> $urandom_range(24, 8);
      end
    endcase
    return c;
  endfunction

  function automatic void set_idle(input idle_mode_e m);
    sender_idle_pct = (m == IDLE_SENDER) ? 61 : ((m == IDLE_BOTH) ? 37 : 0);
    recv_stall_pct  = (m == IDLE_RECEIVER) ? 61 : ((m == IDLE_BOTH) ? 37 : 0);
  endfunction

  // Counts a mismatch and, for the first MAX_PRINTED of them, prints one line about it.
  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTED) begin
      $display("[%0t] ERROR: %s", $realtime, msg);
    end
  endtask

  // Offers one input transaction, with random gaps, and waits until it is accepted.
  task automatic send_item(input logic op, input logic [CHAN_W-1:0] col,
                           input logic [CHAN_W-1:0] row, input logic [CHAN_W-1:0] r,
                           input logic [CHAN_W-1:0] g, input logic [CHAN_W-1:0] b,
                           input logic [COORD_W-1:0] u, input logic [COORD_W-1:0] v);
    @(negedge clk_i);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid  <= 1'b1;
    opcode    <= op;
    texel_col <= col;
    texel_row <= row;
    red_in    <= r;
    green_in  <= g;
    blue_in   <= b;
    coord_u   <= u;
    coord_v   <= v;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    items_sent++;
  endtask

  // Stores one texel; the unused coordinate fields carry random bits.
  task automatic send_write(input logic [CHAN_W-1:0] col, input logic [CHAN_W-1:0] row,
                            input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                            input logic [CHAN_W-1:0] b);
    tex_written[{row, col}] = 1'b1;
    send_item(OP_WRITE, col, row, r, g, b, $urandom, $urandom);
  endtask

  // Samples at (u, v), first loading any of the four texels that was never written.
  task automatic sample_at(input logic [COORD_W-1:0] u, input logic [COORD_W-1:0] v,
                           input bit fixed, input rgb_result_t val);
    taps_t             tp;
    logic [CHAN_W-1:0] xs [2];
    logic [CHAN_W-1:0] ys [2];
    if (model_width != 0) begin
      tp = find_taps(u, v, model_width, model_height);
      xs[0] = tp.x0;
      xs[1] = tp.x1;
      ys[0] = tp.y0;
      ys[1] = tp.y1;
      for (int j = 0; j < 2; j++) begin
        for (int i = 0; i < 2; i++) begin
          if (!tex_written[{ys[j], xs[i]}]) begin
            send_write(xs[i], ys[j], CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom));
          end
        end
      end
    end
    sample_origin_q.push_back('{fixed: fixed, val: val});
    send_item(OP_SAMPLE, CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom),
              CHAN_W'($urandom), CHAN_W'($urandom), u, v);
  endtask

  // Writes one configuration register.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Stops offering input until every pending result has arrived and the block has settled.
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (expected_rgb_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // A random stretch: mostly samples, the rest texel writes in and around the image.
  task automatic random_phase(input int n_items, input bit with_hold);
    int          first;
    bit          hold_done;
    int unsigned eff_w, eff_h;
    first     = items_sent;
    hold_done = 1'b0;
    eff_w = (model_width > TEX_SIDE) ? TEX_SIDE : model_width;
    eff_h = (model_height == 0) ? 1 : ((model_height > TEX_SIDE) ? TEX_SIDE : model_height);
    while (items_sent - first < n_items) begin
      if (with_hold && !hold_done && (items_sent - first) >= 40) begin
        hold_request = 1'b1;
        hold_done    = 1'b1;
      end
      if ($urandom_range(99) < 55) begin
        sample_at(rand_coord(), rand_coord(), 1'b0, '0);
      end else if (eff_w != 0 && $urandom_range(1) == 1) begin
        send_write(CHAN_W'($urandom_range(eff_w - 1)), CHAN_W'($urandom_range(eff_h - 1)),
                   CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom));
      end else begin
        send_write(CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom),
                   CHAN_W'($urandom), CHAN_W'($urandom));
      end
    end
  endtask

  // Receiver: random stalls, or one long hold-off on request.
  always @(negedge clk_i) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: predicts accepted samples, checks accepted results, tracks configuration.
  always @(posedge clk_i) begin
    rgb_result_t    want;
    sample_origin_t origin;
    bit             progress;
    if (rst_ni) begin
      progress = 1'b0;
      if (out_valid && out_ready) begin
        progress = 1'b1;
        if (expected_rgb_q.size() == 0) begin
          report_mismatch("result transaction with no sample pending");
        end else begin
          want = expected_rgb_q.pop_front();
          if (red_out !== want.red) begin
            report_mismatch($sformatf("red_out got %0d expected %0d", red_out, want.red));
          end
          if (green_out !== want.green) begin
            report_mismatch($sformatf("green_out got %0d expected %0d", green_out, want.green));
          end
          if (blue_out !== want.blue) begin
            report_mismatch($sformatf("blue_out got %0d expected %0d", blue_out, want.blue));
          end
        end
      end
      if (in_valid && in_ready) begin
        progress = 1'b1;
        if (opcode == OP_SAMPLE) begin
          origin = sample_origin_q.pop_front();
          want   = origin.fixed ? origin.val
                                : predict_rgb(coord_u, coord_v, model_width, model_height);
          expected_rgb_q.push_back(want);
        end else begin
          texel_shadow[{texel_row, texel_col}] = {red_in, green_in, blue_in};
        end
      end
      if (cfg_valid && cfg_ready) begin
        progress = 1'b1;
        case (cfg_index)
          CFG_IMAGE_WIDTH:  model_width  = cfg_data;
          CFG_IMAGE_HEIGHT: model_height = cfg_data;
          default: begin
          end
        endcase
      end
      cycles_without_progress = progress ? 0 : cycles_without_progress + 1;
    end
  end

  // Watchdog: ends a run that stops making progress.
  initial begin
    wait (cycles_without_progress >= WATCHDOG_LIMIT);
    $display("bilinear_wrap_texture_sampler_top: mismatch");
    $finish;
  end

  // Main sequence: reset, directed table, random phases over several image sizes.
  initial begin
    dir_row_t         row;
    logic [DIM_W-1:0] phase_w [NUM_PHASES];
    logic [DIM_W-1:0] phase_h [NUM_PHASES];
    phase_w = '{9'd4, 9'd1, 9'd3, 9'd256, 9'd2, 9'd511, 9'd0, 9'd17, 9'd1, 9'd5};
    phase_h = '{9'd4, 9'd1, 9'd7, 9'd256, 9'd1, 9'd0, 9'd9, 9'd200, 9'd256, 9'd511};

    directed_rows = '{
      // No image after reset: every sample is pure green.
      tbl_sample_known(32'h0000_0000, 32'h0000_0000, 24'd0, FULL_SCALE, 24'd0),
      tbl_sample_known(32'h7FFF_FFFF, 32'h8000_0000, 24'd0, FULL_SCALE, 24'd0),
      tbl_sample_known(32'h8000_0000, 32'h7FFF_FFFF, 24'd0, FULL_SCALE, 24'd0),
      tbl_sample_known(32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'd0, FULL_SCALE, 24'd0),
      // A one-texel image returns that texel at full weight wherever it is sampled.
      tbl_write(8'd0, 8'd0, 8'hFF, 8'h00, 8'h80),
      tbl_cfg(CFG_IMAGE_WIDTH, 9'd1),
      tbl_cfg(CFG_IMAGE_HEIGHT, 9'd1),
      tbl_sample_known(32'h1234_5678, 32'hFFFF_0000, 24'hFF0000, 24'd0, 24'h800000),
      tbl_sample_known(32'h8000_0000, 32'h7FFF_FFFF, 24'hFF0000, 24'd0, 24'h800000),
      tbl_write(8'd0, 8'd0, 8'h00, 8'hFF, 8'hFF),
      tbl_sample_known(32'h0000_0000, 32'h0000_0000, 24'd0, FULL_SCALE, FULL_SCALE),
      tbl_write(8'd255, 8'd255, 8'hFF, 8'hFF, 8'hFF),
      tbl_write(8'd0, 8'd0, 8'h00, 8'h00, 8'h00),
      tbl_sample_known(32'h0000_FFFF, 32'h0000_8000, 24'd0, 24'd0, 24'd0),
      // Largest image: samples near the origin wrap to the far corner.
      tbl_cfg(CFG_IMAGE_WIDTH, 9'd256),
      tbl_cfg(CFG_IMAGE_HEIGHT, 9'd256),
      tbl_sample(32'h0000_0000, 32'h0000_0000),
      tbl_sample(32'h0000_FFFF, 32'hFFFF_FFFF),
      tbl_sample(32'h7FFF_FFFF, 32'h8000_0000),
      // Oversized width and zero height are clamped.
      tbl_cfg(CFG_IMAGE_WIDTH, 9'd511),
      tbl_cfg(CFG_IMAGE_HEIGHT, 9'd0),
      tbl_sample(32'h0000_8000, 32'h0001_0000),
      // Writes to undecoded indexes must leave the configuration alone.
      tbl_cfg(CFG_SPARE_2, 9'h1FF),
      tbl_cfg(CFG_SPARE_3, 9'h000),
      tbl_sample(32'h4000_8000, 32'h0000_0000),
      // Small odd sizes.
      tbl_cfg(CFG_IMAGE_WIDTH, 9'd3),
      tbl_cfg(CFG_IMAGE_HEIGHT, 9'd5),
      tbl_sample(32'h0000_5555, 32'h0003_0000),
      tbl_sample(32'hFFFF_0001, 32'hFFFC_8000),
      tbl_cfg(CFG_IMAGE_HEIGHT, 9'd256),
      tbl_sample(32'h0000_AAAA, 32'h7FFF_FFFF),
      // Width back to zero: no image again.
      tbl_cfg(CFG_IMAGE_WIDTH, 9'd0),
      tbl_sample_known(32'h5A5A_5A5A, 32'hA5A5_A5A5, 24'd0, FULL_SCALE, 24'd0)
    };

    // Reset.
    set_idle(IDLE_NONE);
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table.
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      case (row.kind)
        ROW_CONFIG: begin
          wait_idle();
          write_reg(row.a[CFG_IDX_W-1:0], row.b);
        end
        ROW_WRITE: begin
          send_write(row.a[CHAN_W-1:0], row.b[CHAN_W-1:0], row.red, row.green, row.blue);
        end
        default: begin
          sample_at(row.u, row.v, row.has_typed, row.typed_rgb);
        end
      endcase
    end

    // Random phases, each with its own image size and idling pattern.
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      write_reg(CFG_IMAGE_WIDTH, phase_w[p]);
      write_reg(CFG_IMAGE_HEIGHT, phase_h[p]);
      set_idle(idle_mode_e'(p % 4));
      random_phase(PHASE_ITEMS, p == HOLD_PHASE);
    end

    // Drain and let the block settle.
    set_idle(IDLE_NONE);
    wait_idle();
    if (expected_rgb_q.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_rgb_q.size()));
    end
    if (mismatches == 0) begin
      $display("bilinear_wrap_texture_sampler_top: match");
    end else begin
      $display("bilinear_wrap_texture_sampler_top: mismatch");
    end
    $finish;
  end

endmodule
